// File: hw/rtl/market_feed_trade_vwap_accumulator_defines.svh
// Assertion macros for the file that checks its own logic.
`ifndef MARKET_FEED_TRADE_VWAP_ACCUMULATOR_DEFINES_SVH
`define MARKET_FEED_TRADE_VWAP_ACCUMULATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mfv_pkg.sv
package mfv_pkg;

	localparam int MAX_TICKERS_DEF = 256;
	localparam int HOURS_PER_DAY   = 24;

	localparam logic [47:0] NS_PER_HOUR = 48'd3600000000000;
	localparam logic [7:0]  TRADE_TYPE  = 8'h50;

	localparam logic [1:0] KIND_TRADE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN = 2'd1;
	localparam logic [1:0] ERR_LENGTH  = 2'd2;
	localparam logic [1:0] ERR_FULL    = 2'd3;

	// Parser event for the accepted beat.
	typedef struct packed {
		logic       err;
		logic [1:0] code;
		logic       trade;
	} mfv_evt_t;

	// Expected frame length per message type; zero marks an unknown type.
	function automatic logic [7:0] msg_len(input logic [7:0] t);
		logic [7:0] r;
		unique case (t)
			8'h53: r = 8'd12;
			8'h52: r = 8'd39;
			8'h48: r = 8'd25;
			8'h59: r = 8'd20;
			8'h4C: r = 8'd26;
			8'h56: r = 8'd35;
			8'h57: r = 8'd12;
			8'h4B: r = 8'd28;
			8'h4A: r = 8'd35;
			8'h68: r = 8'd1;
			8'h41: r = 8'd36;
			8'h46: r = 8'd40;
			8'h45: r = 8'd31;
			8'h43: r = 8'd36;
			8'h58: r = 8'd23;
			8'h44: r = 8'd19;
			8'h55: r = 8'd35;
			8'h50: r = 8'd44;
			8'h51: r = 8'd40;
			8'h42: r = 8'd19;
			8'h49: r = 8'd50;
			8'h4F: r = 8'd1;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/mfv_if.sv
interface mfv_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;
	logic [7:0] read_slot;
	logic [4:0] read_hour;

	modport source (output valid, operation, data_byte, read_slot, read_hour, input ready);
	modport sink (input valid, operation, data_byte, read_slot, read_hour, output ready);
endinterface

interface mfv_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [1:0]  error_code;
	logic [7:0]  ticker_slot;
	logic [63:0] ticker_code;
	logic [4:0]  hour_of_day;
	logic [63:0] total_volume;
	logic [63:0] total_price_volume;

	modport source (output valid, result_kind, error_code, ticker_slot, ticker_code,
		hour_of_day, total_volume, total_price_volume, input ready);
	modport sink (input valid, result_kind, error_code, ticker_slot, ticker_code,
		hour_of_day, total_volume, total_price_volume, output ready);
endinterface

// File: hw/rtl/mfv_ram.sv
module mfv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/mfv_parser.sv
module mfv_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic [7:0]        data_byte,
	output mfv_pkg::mfv_evt_t evt,
	output logic [47:0]       ts,
	output logic [31:0]       shares,
	output logic [63:0]       ticker,
	output logic [31:0]       price
);
	import mfv_pkg::*;

	typedef enum logic [1:0] {PH_LEN_HI, PH_LEN_LO, PH_TYPE, PH_BODY} phase_t;

	phase_t      phase_q;
	logic [15:0] len_q;
	logic [15:0] idx_q;
	logic [7:0]  kind_q;
	logic        halted_q;
	logic [47:0] ts_q;
	logic [31:0] shares_q;
	logic [63:0] ticker_q;
	logic [31:0] price_q;

	logic [7:0] want;
	logic       bad_type;
	logic       bad_len;
	logic       last;
	logic       live;

	assign want     = msg_len(data_byte);
	assign bad_type = (want == 8'd0);
	assign bad_len  = ({8'd0, want} != len_q);
	assign last     = (({1'b0, idx_q} + 17'd2) >= {1'b0, len_q});
	assign live     = byte_valid && !halted_q;

	always_comb begin
		evt = '0;
		if (live && phase_q == PH_TYPE) begin
			if (bad_type) begin
				evt.err  = 1'b1;
				evt.code = ERR_UNKNOWN;
			end else if (bad_len) begin
				evt.err  = 1'b1;
				evt.code = ERR_LENGTH;
			end
		end
		if (live && phase_q == PH_BODY && last && kind_q == TRADE_TYPE) begin
			evt.trade = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN_HI;
			len_q    <= '0;
			idx_q    <= '0;
			kind_q   <= '0;
			halted_q <= 1'b0;
			ts_q     <= '0;
			shares_q <= '0;
			ticker_q <= '0;
			price_q  <= '0;
		end else if (live) begin
			unique case (phase_q)
				PH_LEN_HI: begin
					len_q   <= {data_byte, 8'h00};
					phase_q <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_q   <= {len_q[15:8], data_byte};
					phase_q <= PH_TYPE;
				end
				PH_TYPE: begin
					kind_q <= data_byte;
					if (bad_type || bad_len) begin
						halted_q <= 1'b1;
					end else begin
						idx_q   <= '0;
						phase_q <= (len_q > 16'd1) ? PH_BODY : PH_LEN_HI;
					end
				end
				PH_BODY: begin
					if (kind_q == TRADE_TYPE) begin
						if (idx_q >= 16'd4 && idx_q <= 16'd9) begin
							ts_q <= {ts_q[39:0], data_byte};
						end else if (idx_q >= 16'd19 && idx_q <= 16'd22) begin
							shares_q <= {shares_q[23:0], data_byte};
						end else if (idx_q >= 16'd23 && idx_q <= 16'd30) begin
							ticker_q <= {ticker_q[55:0], data_byte};
						end else if (idx_q >= 16'd31 && idx_q <= 16'd34) begin
							price_q <= {price_q[23:0], data_byte};
						end
					end
					idx_q <= idx_q + 16'd1;
					if (last) begin
						phase_q <= PH_LEN_HI;
					end
				end
				default: phase_q <= PH_LEN_HI;
			endcase
		end
	end

	assign ts     = ts_q;
	assign shares = shares_q;
	assign ticker = ticker_q;
	assign price  = price_q;
endmodule

// File: hw/rtl/mfv_hour.sv
module mfv_hour (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] ts,
	output logic        busy,
	output logic [4:0]  hour
);
	// The hour length is 2^13 * 439453125 ns, so the quotient comes from ts[47:13].
	// A reciprocal product on the top 20 bits gives an estimate that is exact or one low.
	// One compare and subtract settles it, and the hour is valid once busy falls again.
	localparam logic [28:0] HOUR_ODD = 29'd439453125;
	localparam logic [10:0] RECIP    = 11'd1250;

	logic [34:0] ts_q;
	logic [6:0]  est_q;
	logic [6:0]  quo_q;
	logic        step_q;
	logic        busy_q;

	logic [30:0] prod;
	logic [34:0] back;
	logic [34:0] rem;
	logic        over;
	logic [6:0]  hr;

	assign prod = 31'(ts_q[34:15]) * 31'(RECIP);
	assign back = 35'(est_q) * 35'(HOUR_ODD);
	assign rem  = ts_q - back;
	assign over = (rem >= 35'(HOUR_ODD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 1'b0;
			ts_q   <= '0;
			est_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 1'b1;
			ts_q   <= ts[47:13];
		end else if (busy_q) begin
			if (step_q) begin
				est_q  <= prod[30:24];
				step_q <= 1'b0;
			end else begin
				quo_q  <= est_q + 7'(over);
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (quo_q >= 7'd72) begin
			hr = quo_q - 7'd72;
		end else if (quo_q >= 7'd48) begin
			hr = quo_q - 7'd48;
		end else if (quo_q >= 7'd24) begin
			hr = quo_q - 7'd24;
		end else begin
			hr = quo_q;
		end
	end

	assign busy = busy_q;
	assign hour = hr[4:0];
endmodule

// File: hw/rtl/market_feed_trade_vwap_accumulator.sv
// A read beat is answered from the registered memory read through the result register.
// A trade ends at its last payload beat; the hour division, a key memory search that
// reads and then compares one ticker slot at a time, the table read and the write-back follow.
// Throughput is one item at a time; no beat is taken while a trade or read is in work.
// After reset a clearing pass writes MAX_TICKERS*24 accumulator entries, one per cycle,
// during which no beat is accepted. All control state resets asynchronously.
`include "market_feed_trade_vwap_accumulator_defines.svh"

module market_feed_trade_vwap_accumulator #(
	parameter int MAX_TICKERS = mfv_pkg::MAX_TICKERS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	mfv_in_if.sink   req,
	mfv_out_if.source rsp
);
	import mfv_pkg::*;

	localparam int ENTRIES = MAX_TICKERS * HOURS_PER_DAY;
	localparam int SLOT_W  = (MAX_TICKERS > 1) ? $clog2(MAX_TICKERS) : 1;
	localparam int CNT_W   = $clog2(MAX_TICKERS + 1);
	localparam int EW      = $clog2(ENTRIES);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_READ, S_DIV, S_LOOK_RD, S_LOOK_CMP, S_MISS, S_ACC_RD
	} state_t;

	state_t            state_q;
	logic [EW-1:0]     clr_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] slot_q;
	logic [7:0]        rd_slot_q;
	logic [4:0]        rd_hour_q;
	logic [63:0]       mul_q;
	logic              upd_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [1:0]  out_err_q;
	logic [7:0]  out_slot_q;
	logic [63:0] out_code_q;
	logic [4:0]  out_hour_q;
	logic [63:0] out_vol_q;
	logic [63:0] out_pv_q;

	mfv_evt_t    evt;
	logic [47:0] ts;
	logic [31:0] shares;
	logic [63:0] ticker;
	logic [31:0] price;
	logic        div_busy;
	logic [4:0]  hour;

	logic        accept;
	logic        byte_beat;

	logic              key_we;
	logic [SLOT_W-1:0] key_raddr;
	logic [63:0]       key_rdata;
	logic              tab_we;
	logic [EW-1:0]     tab_waddr;
	logic [EW-1:0]     tab_raddr;
	logic [63:0]       vol_wdata;
	logic [63:0]       pv_wdata;
	logic [63:0]       vol_rdata;
	logic [63:0]       pv_rdata;
	logic [EW-1:0]     trade_entry;
	logic [64:0]       vol_sum;
	logic [64:0]       pv_sum;
	logic [63:0]       vol_sat;
	logic [63:0]       pv_sat;
	logic              rd_slot_ok;
	logic              rd_hour_ok;

	function automatic logic [EW-1:0] entry_of(input logic [SLOT_W-1:0] s,
		input logic [4:0] h);
		return EW'(s) * EW'(HOURS_PER_DAY) + EW'(h);
	endfunction

	assign req.ready = (state_q == S_IDLE) && !upd_q && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign byte_beat = accept && !req.operation;

	mfv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_beat),
		.data_byte (req.data_byte),
		.evt       (evt),
		.ts        (ts),
		.shares    (shares),
		.ticker    (ticker),
		.price     (price)
	);

	mfv_hour u_hour (
		.clk   (clk),
		.arst_n(arst_n),
		.start (evt.trade),
		.ts    (ts),
		.busy  (div_busy),
		.hour  (hour)
	);

	assign trade_entry = entry_of(slot_q, hour);
	assign key_raddr   = (state_q == S_IDLE) ? SLOT_W'(req.read_slot) : idx_q;
	assign tab_raddr   = (state_q == S_IDLE) ?
		entry_of(SLOT_W'(req.read_slot), req.read_hour) : trade_entry;
	assign key_we      = (state_q == S_MISS) && (32'(count_q) < MAX_TICKERS);

	assign vol_sum = {1'b0, vol_rdata} + {33'd0, shares};
	assign pv_sum  = {1'b0, pv_rdata} + {1'b0, mul_q};
	assign vol_sat = vol_sum[64] ? {64{1'b1}} : vol_sum[63:0];
	assign pv_sat  = pv_sum[64] ? {64{1'b1}} : pv_sum[63:0];

	assign tab_we    = (state_q == S_CLEAR) || upd_q;
	assign tab_waddr = (state_q == S_CLEAR) ? clr_q : trade_entry;
	assign vol_wdata = (state_q == S_CLEAR) ? 64'd0 : vol_sat;
	assign pv_wdata  = (state_q == S_CLEAR) ? 64'd0 : pv_sat;

	assign rd_slot_ok = (32'(rd_slot_q) < 32'(count_q));
	assign rd_hour_ok = (32'(rd_hour_q) < HOURS_PER_DAY);

	mfv_ram #(.WIDTH(64), .DEPTH(MAX_TICKERS)) u_keys (
		.clk  (clk),
		.we   (key_we),
		.waddr(SLOT_W'(count_q)),
		.wdata(ticker),
		.raddr(key_raddr),
		.rdata(key_rdata)
	);

	mfv_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_vol (
		.clk  (clk),
		.we   (tab_we),
		.waddr(tab_waddr),
		.wdata(vol_wdata),
		.raddr(tab_raddr),
		.rdata(vol_rdata)
	);

	mfv_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_pv (
		.clk  (clk),
		.we   (tab_we),
		.waddr(tab_waddr),
		.wdata(pv_wdata),
		.raddr(tab_raddr),
		.rdata(pv_rdata)
	);

	always_ff @(posedge clk) begin
		mul_q <= {32'd0, shares} * {32'd0, price};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			slot_q      <= '0;
			rd_slot_q   <= '0;
			rd_hour_q   <= '0;
			upd_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_TRADE;
			out_err_q   <= ERR_NONE;
			out_slot_q  <= '0;
			out_code_q  <= '0;
			out_hour_q  <= '0;
			out_vol_q   <= '0;
			out_pv_q    <= '0;
		end else begin
			upd_q <= 1'b0;
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + EW'(1);
					if (clr_q == EW'(ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (upd_q) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_TRADE;
						out_err_q   <= ERR_NONE;
						out_slot_q  <= 8'(slot_q);
						out_code_q  <= ticker;
						out_hour_q  <= hour;
						out_vol_q   <= vol_sat;
						out_pv_q    <= pv_sat;
					end else if (accept && req.operation) begin
						rd_slot_q <= req.read_slot;
						rd_hour_q <= req.read_hour;
						state_q   <= S_READ;
					end else if (byte_beat && evt.err) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_ERROR;
						out_err_q   <= evt.code;
						out_slot_q  <= '0;
						out_code_q  <= '0;
						out_hour_q  <= '0;
						out_vol_q   <= '0;
						out_pv_q    <= '0;
					end else if (byte_beat && evt.trade) begin
						state_q <= S_DIV;
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					out_kind_q  <= KIND_READ;
					out_err_q   <= ERR_NONE;
					out_slot_q  <= rd_slot_q;
					out_code_q  <= rd_slot_ok ? key_rdata : 64'd0;
					out_hour_q  <= rd_hour_q;
					out_vol_q   <= (rd_slot_ok && rd_hour_ok) ? vol_rdata : 64'd0;
					out_pv_q    <= (rd_slot_ok && rd_hour_ok) ? pv_rdata : 64'd0;
					state_q     <= S_IDLE;
				end
				S_DIV: begin
					idx_q <= '0;
					if (!div_busy) begin
						state_q <= (count_q == '0) ? S_MISS : S_LOOK_RD;
					end
				end
				S_LOOK_RD: begin
					state_q <= S_LOOK_CMP;
				end
				S_LOOK_CMP: begin
					if (key_rdata == ticker) begin
						slot_q  <= idx_q;
						state_q <= S_ACC_RD;
					end else if (CNT_W'(idx_q) + CNT_W'(1) == count_q) begin
						state_q <= S_MISS;
					end else begin
						idx_q   <= idx_q + SLOT_W'(1);
						state_q <= S_LOOK_RD;
					end
				end
				S_MISS: begin
					if (32'(count_q) >= MAX_TICKERS) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_ERROR;
						out_err_q   <= ERR_FULL;
						out_slot_q  <= '0;
						out_code_q  <= ticker;
						out_hour_q  <= hour;
						out_vol_q   <= '0;
						out_pv_q    <= '0;
						state_q     <= S_IDLE;
					end else begin
						slot_q  <= SLOT_W'(count_q);
						count_q <= count_q + CNT_W'(1);
						state_q <= S_ACC_RD;
					end
				end
				S_ACC_RD: begin
					// Table data arrives next cycle; the write-back and the result
					// happen together while the block is back in idle with ready low.
					upd_q   <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.result_kind        = out_kind_q;
	assign rsp.error_code         = out_err_q;
	assign rsp.ticker_slot        = out_slot_q;
	assign rsp.ticker_code        = out_code_q;
	assign rsp.hour_of_day        = out_hour_q;
	assign rsp.total_volume       = out_vol_q;
	assign rsp.total_price_volume = out_pv_q;

	`MFV_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_q) <= MAX_TICKERS, "ticker count overflow")
	`MFV_ASSERT_NOW(a_upd_no_accept, upd_q, !req.ready, "beat accepted during write-back")
	`MFV_ASSERT_NEXT(a_upd_result, upd_q, rsp.valid && rsp.result_kind == KIND_TRADE,
		"write-back without trade result")
	`MFV_ASSERT_NOW(a_upd_out_free, state_q == S_ACC_RD, !out_valid_q,
		"trade result would overwrite a pending beat")
endmodule
